### rtl/core/hmf_pkg.sv
package hmf_pkg;

    // field widths of the channels
    localparam int SAMPLE_W     = 12;
    localparam int MODE_VALUE_W = 12;
    localparam int MODE_COUNT_W = 20;

    // histogram geometry
    localparam int VALUE_BITS = 12;
    localparam int COUNT_BITS = 20;

    localparam logic [VALUE_BITS-1:0] BIN_LAST  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [VALUE_BITS-1:0] t_bin_addr;
    typedef logic [COUNT_BITS-1:0] t_count;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_ACCUM,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // scan stream from the sequencer to the best tracker
    typedef struct packed {
        logic      valid;
        logic      first;
        t_bin_addr addr;
        t_count    count;
        logic      load;
    } t_scan_ctl;

endpackage

### rtl/core/hmf_if.sv
// sample channel
interface hmf_sample_if;
    import hmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// result channel
interface hmf_result_if;
    import hmf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_VALUE_W-1:0] mode_value;
    logic [MODE_COUNT_W-1:0] mode_count;

    modport source (output valid, output mode_value, output mode_count, input ready);
    modport sink   (input valid, input mode_value, input mode_count, output ready);
endinterface

### rtl/core/histogram_mode_finder.sv
// histogram mode finder
// samples enter on i_sample_ch (sample, last); each one adds to the count
// bin of its value, saturating at the bin maximum
// samples are taken one per cycle back to back while accumulating: each is one
// read-modify-write of the bin memory, with the write forwarded to a following
// item of the same value
// the item flagged last is counted, then one pass over all 4096 bins reads
// each bin, compares it with the running maximum and writes it back as zero
// the result (mode_value, mode_count) appears on o_result_ch once that pass is
// done; samples are not accepted during that pass
// ties go to the smallest value
// the result sits in an output register; a stalled receiver does not block
// new samples until the next scan is done, then the block holds that result
// and takes no samples until the waiting one has been taken
// after reset a clearing pass over all 4096 bins zeroes the bin memory before
// the first sample is accepted
module histogram_mode_finder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hmf_sample_if.sink    i_sample_ch,
    hmf_result_if.source  o_result_ch
);
    import hmf_pkg::*;

    t_scan_ctl scan;
    logic      can_load;

    // sequencer with bin memory
    hmf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (i_sample_ch),
        .i_can_load  (can_load),
        .o_scan      (scan)
    );

    // maximum tracker and result register
    hmf_best u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan      (scan),
        .o_can_load  (can_load),
        .o_result_ch (o_result_ch)
    );

    // no sample taken while bins are being scanned
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan.valid |-> !i_sample_ch.ready)
        else $error("sample accepted during scan");

    // a loaded result shows up next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan.load |=> o_result_ch.valid)
        else $error("result lost after load");

    // a result always counts at least the last sample
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_ch.valid |-> (o_result_ch.mode_count != '0))
        else $error("result with zero count");

    // a new result only comes from a load
    a_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_ch.valid) |-> $past(scan.load))
        else $error("result without load");

endmodule

### rtl/core/hmf_bin_ram.sv
module hmf_bin_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/hmf_seq.sv
module hmf_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hmf_sample_if.sink          i_sample_ch,
    input  logic                i_can_load,
    output hmf_pkg::t_scan_ctl  o_scan
);
    import hmf_pkg::*;

    t_state    r_state, n_state;
    t_bin_addr r_clr_addr;
    logic      r_p_valid, r_p_last;
    t_bin_addr r_p_addr;
    logic      r_fw_valid;
    t_bin_addr r_fw_addr;
    t_count    r_fw_data;
    t_bin_addr r_scan_addr;
    logic      r_issue;
    logic      r_s_valid;
    t_bin_addr r_s_addr;

    t_bin_addr sample_idx;
    logic      accept;
    logic      start_scan;
    logic      n_s_valid;
    t_bin_addr n_s_addr;
    t_bin_addr rd_addr;
    t_count    rd_data;
    logic      wr_en;
    t_bin_addr wr_addr;
    t_count    wr_data;
    t_bin_addr q_addr;
    t_count    cur_count;
    t_count    inc_count;

    assign sample_idx = VALUE_BITS'(i_sample_ch.sample);
    assign accept     = i_sample_ch.valid && i_sample_ch.ready;
    assign start_scan = (r_state == ST_ACCUM) && r_p_valid && r_p_last;

    // bin store
    hmf_bin_ram #(
        .ADDR_BITS(VALUE_BITS),
        .DATA_BITS(COUNT_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // read data with forwarding of the write done at the read edge
    assign q_addr    = r_p_valid ? r_p_addr : r_s_addr;
    assign cur_count = (r_fw_valid && (r_fw_addr == q_addr)) ? r_fw_data : rd_data;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BIN_LAST) n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (start_scan) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_s_valid && (r_s_addr == BIN_LAST)) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_can_load) n_state = ST_ACCUM;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs: handshake, memory ports, scan stream
    always_comb begin
        i_sample_ch.ready = (r_state == ST_ACCUM) && !(r_p_valid && r_p_last);
        wr_en   = 1'b0;
        wr_addr = r_p_addr;
        wr_data = inc_count;
        rd_addr = sample_idx;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            ST_ACCUM: begin
                wr_en = r_p_valid;
                if (r_p_valid && r_p_last) rd_addr = '0;
            end
            ST_SCAN: begin
                // clear each bin once it has been compared
                wr_en   = r_s_valid;
                wr_addr = r_s_addr;
                wr_data = '0;
                rd_addr = r_scan_addr;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        o_scan.valid = r_s_valid;
        o_scan.first = (r_s_addr == '0);
        o_scan.addr  = r_s_addr;
        o_scan.count = cur_count;
        o_scan.load  = (r_state == ST_FINISH) && i_can_load;
    end

    // scan read pipeline
    assign n_s_valid = start_scan || ((r_state == ST_SCAN) && r_issue);
    assign n_s_addr  = start_scan ? '0 : r_scan_addr;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_p_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_issue    <= 1'b0;
            r_s_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p_valid  <= accept;
            r_fw_valid <= wr_en;
            r_s_valid  <= n_s_valid;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (start_scan) begin
                r_issue <= 1'b1;
            end else if ((r_state == ST_SCAN) && (r_scan_addr == BIN_LAST)) begin
                r_issue <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_addr  <= sample_idx;
        r_p_last  <= i_sample_ch.last;
        r_fw_addr <= wr_addr;
        r_fw_data <= wr_data;
        r_s_addr  <= n_s_addr;
        if (start_scan) begin
            r_scan_addr <= t_bin_addr'(1);
        end else if ((r_state == ST_SCAN) && r_issue) begin
            r_scan_addr <= r_scan_addr + 1'b1;
        end
    end

endmodule

### rtl/core/hmf_best.sv
module hmf_best (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hmf_pkg::t_scan_ctl  i_scan,
    output logic                o_can_load,
    hmf_result_if.source        o_result_ch
);
    import hmf_pkg::*;

    t_bin_addr               r_best_value;
    t_count                  r_best_count;
    logic                    r_out_valid;
    logic [MODE_VALUE_W-1:0] r_mode_value;
    logic [MODE_COUNT_W-1:0] r_mode_count;

    assign o_can_load = !r_out_valid || o_result_ch.ready;

    // running maximum, first bin seeds it, ties keep the lower value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_value <= '0;
            r_best_count <= '0;
        end else if (i_scan.valid && (i_scan.first || (i_scan.count > r_best_count))) begin
            r_best_value <= i_scan.addr;
            r_best_count <= i_scan.count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_scan.load) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.load) begin
            r_mode_value <= MODE_VALUE_W'(r_best_value);
            r_mode_count <= MODE_COUNT_W'(r_best_count);
        end
    end

    assign o_result_ch.valid      = r_out_valid;
    assign o_result_ch.mode_value = r_mode_value;
    assign o_result_ch.mode_count = r_mode_count;

endmodule

### tb/histogram_mode_finder_tb.sv
module histogram_mode_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmf_pkg::*;

    localparam int NUM_BINS     = 1 << VALUE_BITS;
    localparam int RANDOM_ITEMS = 880;
    localparam int CALM_ITEMS   = 40;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 4200;
    localparam int PRINT_CAP    = 40;

    // how the values of one random data set are drawn
    typedef enum int {
        MIX_SPREAD,
        MIX_POOL,
        MIX_DOMINANT,
        MIX_EDGES
    } t_set_mix;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        bit                  wait_drain;
    } t_sample_item;

    typedef struct {
        logic [MODE_VALUE_W-1:0] value;
        logic [MODE_COUNT_W-1:0] count;
    } t_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmf_sample_if smp ();
    hmf_result_if res ();

    histogram_mode_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp),
        .o_result_ch (res)
    );

    t_sample_item sample_q[$];
    t_mode        mode_q[$];
    t_count       hist_bins[NUM_BINS];

    logic        sample_fire = 1'b0;
    int unsigned accepted_cnt = 0;
    int unsigned calm_from = 0;
    bit          calm = 1'b0;
    int unsigned idle_rate = 2;
    int unsigned cycle_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned random_cnt = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
        end
        mismatch_cnt++;
    endtask

    // histogram predictor: count one sample, on last scan for the mode and clear
    function automatic void count_sample(logic [SAMPLE_W-1:0] s, logic l);
        t_bin_addr bin;
        t_mode     m;
        bin = s[VALUE_BITS-1:0];
        if (hist_bins[bin] != COUNT_MAX) begin
            hist_bins[bin]++;
        end
        if (l) begin
            m.value = '0;
            m.count = hist_bins[0];
            for (int i = 1; i < NUM_BINS; i++) begin
                if (hist_bins[i] > m.count) begin
                    m.count = hist_bins[i];
                    m.value = MODE_VALUE_W'(i);
                end
            end
            mode_q.push_back(m);
            foreach (hist_bins[i]) hist_bins[i] = '0;
        end
    endfunction

    task automatic push_item(logic [SAMPLE_W-1:0] s, logic l, bit drain);
        t_sample_item it;
        it.sample     = s;
        it.last       = l;
        it.wait_drain = drain;
        sample_q.push_back(it);
    endtask

    // one data set of random length and random value mix
    task automatic push_random_set(bit drain);
        int unsigned         n;
        t_set_mix            mix;
        logic [SAMPLE_W-1:0] pool[4];
        logic [SAMPLE_W-1:0] s;
        n   = $urandom_range(1, 50);
        mix = t_set_mix'($urandom_range(0, 3));
        foreach (pool[k]) pool[k] = SAMPLE_W'($urandom_range(0, 4095));
        for (int j = 0; j < n; j++) begin
            case (mix)
                MIX_SPREAD: begin
                    s = SAMPLE_W'($urandom_range(0, 4095));
                end
                MIX_POOL: begin
                    s = pool[$urandom_range(0, 3)];
                end
                MIX_DOMINANT: begin
                    s = ($urandom_range(0, 3) != 0) ? pool[0]
                                                    : SAMPLE_W'($urandom_range(0, 4095));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       s = '0;
                        1:       s = SAMPLE_W'(1);
                        2:       s = '1 - SAMPLE_W'(1);
                        default: s = '1;
                    endcase
                end
            endcase
            push_item(s, j == n - 1, drain && j == 0);
            random_cnt++;
        end
    endtask

    // sample driver: holds an offered item until taken
    always @(negedge i_clk) begin
        logic                nxt_valid;
        logic [SAMPLE_W-1:0] nxt_sample;
        logic                nxt_last;
        nxt_valid  = 1'b0;
        nxt_sample = smp.sample;
        nxt_last   = smp.last;
        if (i_rst_n) begin
            if (sample_fire) begin
                void'(sample_q.pop_front());
                accepted_cnt++;
            end
            calm = (accepted_cnt >= calm_from);
            if (smp.valid && !sample_fire) begin
                nxt_valid = 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
            end else if (sample_q.size() != 0) begin
                if (sample_q[0].wait_drain && mode_q.size() != 0) begin
                    // hold off until every pending mode has come back
                end else if (!calm && $urandom_range(0, 15) < idle_rate) begin
                    send_gap = $urandom_range(0, 3);
                end else begin
                    nxt_valid  = 1'b1;
                    nxt_sample = sample_q[0].sample;
                    nxt_last   = sample_q[0].last;
                end
            end
        end
        smp.valid  <= nxt_valid;
        smp.sample <= nxt_sample;
        smp.last   <= nxt_last;
    end

    // result receiver with random stall bursts
    always @(negedge i_clk) begin
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (recv_gap > 0) begin
                recv_gap--;
            end else if (!calm && $urandom_range(0, 15) < idle_rate) begin
                recv_gap = $urandom_range(0, 3);
            end else begin
                nxt_ready = 1'b1;
            end
        end
        res.ready <= nxt_ready;
    end

    // monitor: feed the predictor and check every result
    always @(posedge i_clk) begin
        t_mode want;
        sample_fire <= i_rst_n && smp.valid && (smp.ready === 1'b1);
        if (i_rst_n && smp.valid && smp.ready === 1'b1) begin
            count_sample(smp.sample, smp.last);
        end
        if (i_rst_n && res.valid === 1'b1 && res.ready) begin
            if (mode_q.size() == 0) begin
                report_mismatch("result with nothing expected, value", res.mode_value, 0);
            end else begin
                want = mode_q.pop_front();
                if (res.mode_value !== want.value) begin
                    report_mismatch("mode_value", res.mode_value, want.value);
                end
                if (res.mode_count !== want.count) begin
                    report_mismatch("mode_count", res.mode_count, want.count);
                end
            end
        end
    end

    // watchdog on cycles with no item moving; also varies the idling rate
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt % 256 == 0) begin
            idle_rate = $urandom_range(0, 4);
        end
        if ((smp.valid && smp.ready === 1'b1) || (res.valid === 1'b1 && res.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles with no item moving", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        smp.valid  = 1'b0;
        smp.sample = '0;
        smp.last   = 1'b0;
        res.ready  = 1'b0;
        i_rst_n    = 1'b0;
        foreach (hist_bins[i]) hist_bins[i] = '0;

        // directed: lone extremes, ties, repeats, zero bin in the running
        push_item('0, 1'b1, 1'b0);
        push_item('1, 1'b1, 1'b0);
        push_item('1, 1'b0, 1'b0);
        push_item(SAMPLE_W'(7), 1'b0, 1'b0);
        push_item('1, 1'b0, 1'b0);
        push_item(SAMPLE_W'(7), 1'b1, 1'b0);
        push_item(SAMPLE_W'(3), 1'b0, 1'b0);
        push_item(SAMPLE_W'(3), 1'b0, 1'b0);
        push_item(SAMPLE_W'(3), 1'b1, 1'b0);
        push_item('0, 1'b0, 1'b0);
        push_item(SAMPLE_W'(100), 1'b0, 1'b0);
        push_item(SAMPLE_W'(100), 1'b1, 1'b0);
        push_item('0, 1'b0, 1'b0);
        push_item('1, 1'b1, 1'b0);
        push_item(SAMPLE_W'('hAAA), 1'b0, 1'b0);
        push_item(SAMPLE_W'('h555), 1'b1, 1'b0);

        // random data sets, the first one after a full drain
        push_random_set(1'b1);
        while (random_cnt < RANDOM_ITEMS) begin
            push_random_set($urandom_range(0, 7) == 0);
        end

        // closing data set of repeats, sent back to back with no idling
        calm_from = sample_q.size();
        for (int j = 0; j < CALM_ITEMS; j++) begin
            push_item(SAMPLE_W'('hAAA), 1'b0, 1'b0);
        end
        push_item(SAMPLE_W'('h555), 1'b1, 1'b0);

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for everything to drain, then watch for stray results
        while (sample_q.size() != 0 || mode_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
